// File: rtl/qhd_pkg.sv
`timescale 1ns / 1ps

package qhd_pkg;

  localparam int SEED_W = 30;
  localparam logic [4:0] SEED_BITS = 5'd30;

  localparam int TAP_A = 6;
  localparam int TAP_B = 27;
  localparam int TAP_C = 28;
  localparam int TAP_D = 29;

  localparam logic [3:0] MARK_PROBLEM_LIMIT = 4'd10;
  localparam logic [3:0] MARK_PROBLEM_MAX = 4'd15;
  localparam logic [7:0] RC_MAX = 8'd255;
  localparam logic [7:0] RC_WRAP = 8'd252;
  localparam logic [7:0] RC_RESET = 8'd1;
  localparam logic [7:0] RC_SEARCH = 8'd2;
  localparam logic [6:0] DELAY_RESET = 7'd8;

  typedef logic signed [1:0] hel_t;
  typedef logic [SEED_W-1:0] seed_t;

  localparam hel_t HEL_UNK = 2'sb00;
  localparam hel_t HEL_PLUS = 2'sb01;
  localparam hel_t HEL_MINUS = 2'sb11;

  function automatic seed_t lfsr_step(input seed_t s);
    logic nb;
    nb = s[TAP_A] ^ s[TAP_B] ^ s[TAP_C] ^ s[TAP_D];
    return {s[SEED_W-2:0], nb};
  endfunction

  function automatic hel_t seed_hel(input seed_t s);
    return s[0] ? HEL_PLUS : HEL_MINUS;
  endfunction

  function automatic hel_t hel_neg(input hel_t h);
    return hel_t'(~h + 2'sb01);
  endfunction

  function automatic hel_t by_phase(input hel_t start, input logic [1:0] phase);
    return (phase == 2'd0 || phase == 2'd3) ? start : hel_neg(start);
  endfunction

endpackage

// File: rtl/quartet_helicity_decoder_core.sv
`timescale 1ns / 1ps

// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | plus_bit minus_bit blanking quartet_mark window_start
// out     | output    | out_valid/out_ready | actual_helicity predicted_helicity reported_helicity
//         |           |                     | quartet_phase seed_locked
// cfg     | input     | cfg_wr_en           | cfg_wr_data (delay_cycles)
//
// an ordinary event is decoded in the accept cycle; its result sits in the output
// register and the next event is taken once that register empties or is read the same cycle.
// the event that completes the seed also runs the lfsr stepper on the actual seed:
// the block stays busy after it, stepping that seed ahead by delay_cycles/4 quartets.
// rst is synchronous and brings delay_cycles to 8 with no seed and no quartet phase.
// a stalled output holds its transaction and blocks input acceptance.
module quartet_helicity_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                plus_bit,
  input  logic                minus_bit,
  input  logic                blanking,
  input  logic                quartet_mark,
  input  logic                window_start,
  output logic                out_valid,
  input  logic                out_ready,
  output qhd_pkg::hel_t       actual_helicity,
  output qhd_pkg::hel_t       predicted_helicity,
  output qhd_pkg::hel_t       reported_helicity,
  output logic [1:0]          quartet_phase,
  output logic                seed_locked,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data
);
  import qhd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_STEP = 2'b10
  } state_t;

  state_t     state;
  logic [4:0] step_count;
  logic [6:0] delay_cycles;

  seed_t      reported_seed, reported_seed_next;
  seed_t      actual_seed, actual_seed_next;
  logic [4:0] seed_bit_count, seed_bit_count_next;
  logic [7:0] relative_cycle, relative_cycle_next;
  hel_t       window_history [4];
  hel_t       window_history_next [4];
  logic       have_quartet_mark, have_quartet_mark_next;
  logic       phase_found, phase_found_next;
  logic [3:0] mark_problem_count, mark_problem_count_next;
  hel_t       start_actual, start_actual_next;
  hel_t       start_predicted, start_predicted_next;
  logic       quartet_advanced, quartet_advanced_next;

  hel_t       rep, act, pred, a_hel, p_hel;
  logic [7:0] rc_inc;
  logic [1:0] phase, phase2;
  logic [3:0] mpc_bump;
  logic [4:0] count_inc;
  logic       pattern_ok, one_bit, lock_start;
  seed_t      seed_base, seed_shift;
  seed_t      actual_step, reported_step;
  logic       accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // shared lfsr stepper on the actual seed, used per quartet and during lock stepping
  assign actual_step = lfsr_step(actual_seed);
  assign reported_step = lfsr_step(reported_seed);

  always_comb begin
    reported_seed_next = reported_seed;
    actual_seed_next = actual_seed;
    seed_bit_count_next = seed_bit_count;
    relative_cycle_next = relative_cycle;
    for (int i = 0; i < 4; i++) window_history_next[i] = window_history[i];
    have_quartet_mark_next = have_quartet_mark;
    phase_found_next = phase_found;
    mark_problem_count_next = mark_problem_count;
    start_actual_next = start_actual;
    start_predicted_next = start_predicted;
    quartet_advanced_next = quartet_advanced;
    act = HEL_UNK;
    pred = HEL_UNK;
    lock_start = 1'b0;
    a_hel = HEL_UNK;
    p_hel = HEL_UNK;
    one_bit = 1'b0;
    seed_base = '0;
    seed_shift = '0;
    count_inc = '0;
    phase2 = relative_cycle[1:0];

    rep = plus_bit ? (minus_bit ? HEL_UNK : HEL_PLUS) : (minus_bit ? HEL_MINUS : HEL_UNK);
    rc_inc = (relative_cycle == RC_MAX) ? RC_WRAP : relative_cycle + 8'd1;
    phase = rc_inc[1:0];
    mpc_bump = (mark_problem_count == MARK_PROBLEM_MAX) ? MARK_PROBLEM_MAX
                                                        : mark_problem_count + 4'd1;
    // +--+ or -++- over the four newest windows
    pattern_ok = (rep == window_history[2]) && (window_history[0] == window_history[1]) &&
                 (rep != HEL_UNK) && (window_history[0] != HEL_UNK) &&
                 (rep != window_history[0]);

    if (delay_cycles == 7'd0) begin
      act = blanking ? HEL_UNK : rep;
    end else if (blanking) begin
      act = HEL_UNK;
    end else if (window_start) begin
      window_history_next[0] = rep;
      window_history_next[1] = window_history[0];
      window_history_next[2] = window_history[1];
      window_history_next[3] = window_history[2];
      relative_cycle_next = rc_inc;

      if (quartet_mark) begin
        quartet_advanced_next = (phase == 2'd0);
        if (have_quartet_mark) begin
          if (phase != 2'd0) begin
            mark_problem_count_next = mpc_bump;
            if (mpc_bump > MARK_PROBLEM_LIMIT) begin
              have_quartet_mark_next = 1'b0;
              phase_found_next = 1'b0;
              mark_problem_count_next = '0;
            end
          end else begin
            mark_problem_count_next = '0;
          end
        end
        if (!have_quartet_mark_next) begin
          have_quartet_mark_next = 1'b1;
          phase_found_next = 1'b1;
          relative_cycle_next = '0;
          quartet_advanced_next = 1'b1;
          seed_bit_count_next = '0;
          mark_problem_count_next = '0;
        end
      end else if (have_quartet_mark) begin
        quartet_advanced_next = (phase == 2'd0);
        if (phase == 2'd0) begin
          mark_problem_count_next = mpc_bump;
          if (mpc_bump > MARK_PROBLEM_LIMIT) begin
            have_quartet_mark_next = 1'b0;
            seed_bit_count_next = '0;
            quartet_advanced_next = 1'b0;
          end
        end
      end else if (phase == 2'd3) begin
        if (pattern_ok) begin
          if (!phase_found) begin
            quartet_advanced_next = 1'b1;
            phase_found_next = 1'b1;
          end
        end else begin
          relative_cycle_next = RC_SEARCH;
          phase_found_next = 1'b0;
          seed_bit_count_next = '0;
        end
      end else begin
        quartet_advanced_next = (phase == 2'd0);
      end

      phase2 = relative_cycle_next[1:0];
      if (phase_found_next) begin
        if (seed_bit_count_next < SEED_BITS) begin
          if (quartet_advanced_next) begin
            one_bit = (rep == HEL_PLUS && (phase2 == 2'd0 || phase2 == 2'd3)) ||
                      (rep == HEL_MINUS && (phase2 == 2'd1 || phase2 == 2'd2));
            seed_base = (seed_bit_count_next == 5'd0) ? '0 : reported_seed;
            seed_shift = {seed_base[SEED_W-2:0], one_bit};
            count_inc = seed_bit_count_next + 5'd1;
            if (rep == HEL_UNK) begin
              seed_bit_count_next = '0;
              reported_seed_next = '0;
            end else begin
              seed_bit_count_next = count_inc;
              reported_seed_next = seed_shift;
              if (count_inc == SEED_BITS) begin
                actual_seed_next = seed_shift;
                start_predicted_next = seed_hel(seed_shift);
                lock_start = 1'b1;
              end
            end
          end
        end else if (phase2 == 2'd0) begin
          reported_seed_next = reported_step;
          actual_seed_next = actual_step;
          a_hel = seed_hel(actual_step);
          p_hel = seed_hel(reported_step);
          if (rep != p_hel) begin
            seed_bit_count_next = '0;
            a_hel = HEL_UNK;
            p_hel = HEL_UNK;
          end
          start_actual_next = a_hel;
          start_predicted_next = p_hel;
          act = by_phase(a_hel, phase2);
          pred = by_phase(p_hel, phase2);
        end else begin
          act = by_phase(start_actual, phase2);
          pred = by_phase(start_predicted, phase2);
        end
      end
    end else if (seed_bit_count >= SEED_BITS) begin
      act = by_phase(seed_hel(actual_seed), relative_cycle[1:0]);
      pred = by_phase(seed_hel(reported_seed), relative_cycle[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_count <= '0;
      delay_cycles <= DELAY_RESET;
      reported_seed <= '0;
      actual_seed <= '0;
      seed_bit_count <= '0;
      relative_cycle <= RC_RESET;
      for (int i = 0; i < 4; i++) window_history[i] <= HEL_UNK;
      have_quartet_mark <= 1'b0;
      phase_found <= 1'b0;
      mark_problem_count <= '0;
      start_actual <= HEL_UNK;
      start_predicted <= HEL_UNK;
      quartet_advanced <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        delay_cycles <= cfg_wr_data;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            reported_seed <= reported_seed_next;
            actual_seed <= actual_seed_next;
            seed_bit_count <= seed_bit_count_next;
            relative_cycle <= relative_cycle_next;
            for (int i = 0; i < 4; i++) window_history[i] <= window_history_next[i];
            have_quartet_mark <= have_quartet_mark_next;
            phase_found <= phase_found_next;
            mark_problem_count <= mark_problem_count_next;
            start_actual <= start_actual_next;
            start_predicted <= start_predicted_next;
            quartet_advanced <= quartet_advanced_next;
            if (lock_start) begin
              step_count <= delay_cycles[6:2];
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          // run the actual seed ahead by delay/4 quartets
          if (step_count == 5'd0) begin
            start_actual <= seed_hel(actual_seed);
            state <= S_IDLE;
          end else begin
            actual_seed <= actual_step;
            step_count <= step_count - 5'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      actual_helicity <= act;
      predicted_helicity <= pred;
      reported_helicity <= rep;
      quartet_phase <= relative_cycle_next[1:0];
      seed_locked <= (seed_bit_count_next >= SEED_BITS);
    end
  end

endmodule

// File: tb/sv/helicity_decode_checker.sv
`timescale 1ns / 1ps

module helicity_decode_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic          plus_bit,
  input  logic          minus_bit,
  input  logic          blanking,
  input  logic          quartet_mark,
  input  logic          window_start,
  input  logic          out_valid,
  input  logic          out_ready,
  input  qhd_pkg::hel_t actual_helicity,
  input  qhd_pkg::hel_t predicted_helicity,
  input  qhd_pkg::hel_t reported_helicity,
  input  logic [1:0]    quartet_phase,
  input  logic          seed_locked,
  input  logic          cfg_wr_en,
  input  logic [6:0]    cfg_wr_data,
  output int            failures,
  output int            pending
);

  import qhd_pkg::*;

  localparam int SEED_COUNT = 30;
  localparam int PROBLEM_LIMIT = 10;
  localparam int PROBLEM_SAT = 15;

  typedef struct packed {
    hel_t       act;
    hel_t       pred;
    hel_t       rep;
    logic [1:0] phase;
    logic       locked;
  } decode_t;

  decode_t expected_decodes[$];
  int fail_total = 0;

  logic [6:0] delay_q;
  seed_t      rep_seed;
  seed_t      act_seed;
  int         bit_cnt;
  int         rel_cycle;
  int         hist[4];
  bit         have_mark;
  bit         phase_found;
  int         problems;
  int         start_act;
  int         start_pred;
  bit         q_adv;

  assign failures = fail_total;

  function automatic seed_t lfsr_next(input seed_t s);
    return {s[28:0], s[6] ^ s[27] ^ s[28] ^ s[29]};
  endfunction

  function automatic int seed_sign(input seed_t s);
    return s[0] ? 1 : -1;
  endfunction

  function automatic int quartet_sign(input int start, input int ph);
    return (ph == 0 || ph == 3) ? start : -start;
  endfunction

  task automatic clear_decoder();
    delay_q = DELAY_RESET;
    rep_seed = '0;
    act_seed = '0;
    bit_cnt = 0;
    rel_cycle = 1;
    foreach (hist[i]) hist[i] = 0;
    have_mark = 0;
    phase_found = 0;
    problems = 0;
    start_act = 0;
    start_pred = 0;
    q_adv = 0;
  endtask

  task automatic decode_event(input logic p, input logic m, input logic blank,
                              input logic mark, input logic wstart, output decode_t r);
    int rep;
    int act;
    int pred;
    int ph;
    int sum;
    bit one;
    rep = p ? (m ? 0 : 1) : (m ? -1 : 0);
    act = 0;
    pred = 0;
    if (delay_q == 0) begin
      act = blank ? 0 : rep;
    end else if (blank) begin
      act = 0;
    end else if (wstart) begin
      hist[3] = hist[2];
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = rep;
      rel_cycle++;
      if (rel_cycle > 255) rel_cycle = 252;
      ph = rel_cycle & 3;
      if (mark) begin
        q_adv = (ph == 0);
        if (have_mark) begin
          if (ph != 0) begin
            if (problems < PROBLEM_SAT) problems++;
            if (problems > PROBLEM_LIMIT) begin
              have_mark = 0;
              phase_found = 0;
              problems = 0;
            end
          end else begin
            problems = 0;
          end
        end
        if (!have_mark) begin
          have_mark = 1;
          phase_found = 1;
          rel_cycle = 0;
          q_adv = 1;
          bit_cnt = 0;
          problems = 0;
        end
      end else if (have_mark) begin
        q_adv = (ph == 0);
        if (ph == 0) begin
          if (problems < PROBLEM_SAT) problems++;
          if (problems > PROBLEM_LIMIT) begin
            have_mark = 0;
            bit_cnt = 0;
            q_adv = 0;
          end
        end
      end else if (ph == 3) begin
        // +--+ or -++- over the last four windows
        sum = hist[0] + hist[3] - hist[1] - hist[2];
        if (sum == 4 || sum == -4) begin
          if (!phase_found) begin
            q_adv = 1;
            phase_found = 1;
          end
        end else begin
          rel_cycle = 2;
          phase_found = 0;
          bit_cnt = 0;
        end
      end else begin
        q_adv = (ph == 0);
      end

      ph = rel_cycle & 3;
      if (phase_found) begin
        if (bit_cnt < SEED_COUNT) begin
          if (q_adv) begin
            one = (rep == 1 && (ph == 0 || ph == 3)) || (rep == -1 && (ph == 1 || ph == 2));
            if (bit_cnt == 0) rep_seed = '0;
            rep_seed = {rep_seed[28:0], one};
            bit_cnt++;
            if (rep == 0) begin
              bit_cnt = 0;
              rep_seed = '0;
            end else if (bit_cnt == SEED_COUNT) begin
              act_seed = rep_seed;
              for (int i = 0; i < int'(delay_q >> 2); i++) act_seed = lfsr_next(act_seed);
              start_act = seed_sign(act_seed);
              start_pred = seed_sign(rep_seed);
            end
          end
        end else begin
          if (ph == 0) begin
            rep_seed = lfsr_next(rep_seed);
            act_seed = lfsr_next(act_seed);
            start_act = seed_sign(act_seed);
            start_pred = seed_sign(rep_seed);
            // missed prediction drops the lock
            if (rep != start_pred) begin
              bit_cnt = 0;
              start_act = 0;
              start_pred = 0;
            end
          end
          act = quartet_sign(start_act, ph);
          pred = quartet_sign(start_pred, ph);
        end
      end
    end else if (bit_cnt >= SEED_COUNT) begin
      act = quartet_sign(seed_sign(act_seed), rel_cycle & 3);
      pred = quartet_sign(seed_sign(rep_seed), rel_cycle & 3);
    end
    r.act = hel_t'(act);
    r.pred = hel_t'(pred);
    r.rep = hel_t'(rep);
    r.phase = rel_cycle[1:0];
    r.locked = (bit_cnt >= SEED_COUNT);
  endtask

  always @(posedge clk) begin
    decode_t want;
    decode_t fresh;
    if (rst) begin
      clear_decoder();
      expected_decodes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_decodes.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_total++;
        end else begin
          want = expected_decodes.pop_front();
          if (actual_helicity !== want.act) begin
            $error("actual_helicity expected %0d got %0d", $signed(want.act),
                   $signed(actual_helicity));
            fail_total++;
          end
          if (predicted_helicity !== want.pred) begin
            $error("predicted_helicity expected %0d got %0d", $signed(want.pred),
                   $signed(predicted_helicity));
            fail_total++;
          end
          if (reported_helicity !== want.rep) begin
            $error("reported_helicity expected %0d got %0d", $signed(want.rep),
                   $signed(reported_helicity));
            fail_total++;
          end
          if (quartet_phase !== want.phase) begin
            $error("quartet_phase expected %0d got %0d", want.phase, quartet_phase);
            fail_total++;
          end
          if (seed_locked !== want.locked) begin
            $error("seed_locked expected %0d got %0d", want.locked, seed_locked);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_event(plus_bit, minus_bit, blanking, quartet_mark, window_start, fresh);
        expected_decodes = {expected_decodes, fresh};
      end
      if (cfg_wr_en) delay_q = cfg_wr_data;
    end
    pending <= expected_decodes.size();
  end

  final begin
    if (expected_decodes.size() != 0) begin
      $error("%0d expected results never arrived", expected_decodes.size());
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import qhd_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       plus_bit = 1'b0;
  logic       minus_bit = 1'b0;
  logic       blanking = 1'b0;
  logic       quartet_mark = 1'b0;
  logic       window_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  hel_t       actual_helicity;
  hel_t       predicted_helicity;
  hel_t       reported_helicity;
  logic [1:0] quartet_phase;
  logic       seed_locked;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  int         failures;
  int         pending;

  bit    idle_on = 1'b0;
  bit    hold_req = 1'b0;
  seed_t gen;

  localparam logic [4:0] DIRECTED[20] = '{
    5'b00000, 5'b10000, 5'b01001, 5'b11011, 5'b00111, 5'b10101, 5'b01100,
    5'b10001, 5'b01011, 5'b11111, 5'b00001, 5'b10011, 5'b01001, 5'b11001,
    5'b00010, 5'b10110, 5'b01111, 5'b10001, 5'b00101, 5'b11100
  };
  localparam logic [4:0] IN_TIME[4] = '{5'b10000, 5'b01100, 5'b11000, 5'b00001};

  localparam int MARKS_NONE = 0;
  localparam int MARKS_ALIGNED = 1;
  localparam int MARKS_SHIFTED = 2;

  always #10 clk = ~clk;

  quartet_helicity_decoder_core dut (.*);

  helicity_decode_checker checker_i (.*);

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("tb_top: errors");
    $finish;
  end

  task automatic send_event(input logic [4:0] ev);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {plus_bit, minus_bit, blanking, quartet_mark, window_start} <= ev;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_delay(input logic [6:0] value);
    wait_drained();
    // the lock event keeps the stepper busy after its result
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // free-running lfsr quartets, each window has a window_start
  task automatic play_stream(input int n_items, input int mark_mode, input int noise);
    int sent;
    int w;
    int start;
    int h;
    logic p;
    logic m;
    logic mk;
    logic u;
    sent = 0;
    w = 0;
    start = 1;
    while (sent < n_items) begin
      if (w == 0) begin
        gen = {gen[28:0], gen[6] ^ gen[27] ^ gen[28] ^ gen[29]};
        start = gen[0] ? 1 : -1;
      end
      h = (w == 0 || w == 3) ? start : -start;
      mk = (mark_mode == MARKS_ALIGNED) ? (w == 0) :
           (mark_mode == MARKS_SHIFTED) ? (w == 2) : 1'b0;
      if ($urandom_range(1, noise) == 1) begin
        case ($urandom_range(0, 2))
          0: h = -h;
          1: h = 0;
          default: mk = ~mk;
        endcase
      end
      u = 1'($urandom_range(0, 1));
      p = (h == 1) ? 1'b1 : (h == -1) ? 1'b0 : u;
      m = (h == -1) ? 1'b1 : (h == 1) ? 1'b0 : u;
      if ($urandom_range(0, 3) == 0) begin
        send_event({1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1, mk,
                    1'($urandom_range(0, 1))});
        sent++;
      end
      send_event({p, m, 1'b0, mk, 1'b1});
      sent++;
      if ($urandom_range(0, 3) == 0) begin
        send_event({p, m, 1'b0, mk, 1'b0});
        sent++;
      end
      if ($urandom_range(0, 40) == 0) begin
        send_event(5'($urandom_range(0, 31)));
        sent++;
      end
      w = (w + 1) % 4;
    end
  endtask

  initial begin
    gen = seed_t'($urandom) | seed_t'(1);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) send_event(DIRECTED[i]);
    set_delay(7'd0);
    foreach (IN_TIME[i]) send_event(IN_TIME[i]);

    idle_on = 1'b1;
    set_delay(7'd127);
    play_stream(450, MARKS_ALIGNED, 150);

    set_delay(7'd0);
    play_stream(100, $urandom_range(0, 2), 20);

    set_delay(7'd5);
    hold_req = 1'b1;
    play_stream(250, MARKS_ALIGNED, 150);
    play_stream(60, MARKS_SHIFTED, 150);
    play_stream(150, MARKS_NONE, 150);
    wait_drained();

    set_delay(7'($urandom_range(1, 127)));
    play_stream(250, MARKS_NONE, 150);

    set_delay(7'd3);
    idle_on = 1'b0;
    play_stream(200, MARKS_ALIGNED, 200);

    wait_drained();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
